FILE: sv/plm_pkg.sv
// plm_pkg: shared types and codes for the positional list engine
// operation codes, status codes and the result record; no dependencies
package plm_pkg;

    // operation selector carried in s_tuser
    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_SEARCH = 2'd2;

    // status codes reported with every result item
    localparam logic [2:0] STAT_DONE      = 3'd0;
    localparam logic [2:0] STAT_BAD_POS   = 3'd1;
    localparam logic [2:0] STAT_FULL      = 3'd2;
    localparam logic [2:0] STAT_EMPTY     = 3'd3;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd4;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 7;

    typedef struct packed {
        logic [2:0]       status;
        logic [POS_W-1:0] found_position;
        logic [POS_W-1:0] entry_count;
    } plm_result_t;

endpackage

FILE: sv/plm_store.sv
// plm_store: entry storage, one write port and one registered read port
// depends on plm_pkg for the value width
module plm_store
    import plm_pkg::*;
#(
    parameter int unsigned DEPTH = 64
) (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  logic [VALUE_W-1:0]            wr_data,
    input  logic                          rd_en,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    output logic [VALUE_W-1:0]            rd_data
);

    logic [VALUE_W-1:0] entry_mem [DEPTH];
    logic [VALUE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/plm_ctrl.sv
// plm_ctrl: operation sequencer, shifts entries on insert, drops the rear on delete, scans on search
// depends on plm_pkg; drives the plm_store ports
module plm_ctrl
    import plm_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    in_mode,
    input  logic [POS_W-1:0]              in_position,
    input  logic [VALUE_W-1:0]            in_item_value,
    input  logic [VALUE_W-1:0]            in_search_key,
    output logic                          res_valid,
    input  logic                          res_ready,
    output plm_result_t                   res,
    output logic                          mem_we,
    output logic [$clog2(CAPACITY)-1:0]   mem_waddr,
    output logic [VALUE_W-1:0]            mem_wdata,
    output logic                          mem_re,
    output logic [$clog2(CAPACITY)-1:0]   mem_raddr,
    input  logic [VALUE_W-1:0]            mem_rdata
);

    localparam int unsigned AW   = $clog2(CAPACITY);
    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SHIFT  = 5'b00010,
        S_PUT    = 5'b00100,
        S_SCAN   = 5'b01000,
        S_FINISH = 5'b10000
    } plm_state_t;

    plm_state_t       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [AW-1:0]    tgt_reg, tgt_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [VALUE_W-1:0] key_reg, key_next;
    logic [2:0]       stat_reg, stat_next;
    logic [POS_W-1:0] fpos_reg, fpos_next;

    logic [CMPW-1:0]  pos_w, cnt_w;
    logic             pos_bad, list_full, is_append;

    assign pos_w     = CMPW'(in_position);
    assign cnt_w     = CMPW'(count_reg);
    assign pos_bad   = (in_position == '0) || (pos_w > cnt_w + CMPW'(1));
    assign list_full = cnt_w >= CMPW'(CAPACITY);
    assign is_append = (pos_w - CMPW'(1)) == cnt_w;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        tgt_next   = tgt_reg;
        val_next   = val_reg;
        key_next   = key_reg;
        stat_next  = stat_reg;
        fpos_next  = fpos_reg;
        mem_we     = 1'b0;
        mem_waddr  = idx_reg + AW'(1);
        mem_wdata  = mem_rdata;
        mem_re     = 1'b0;
        mem_raddr  = idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    val_next  = in_item_value;
                    key_next  = in_search_key;
                    fpos_next = '0;
                    tgt_next  = AW'(pos_w - CMPW'(1));
                    unique case (in_mode)
                        MODE_INSERT: begin
                            if (pos_bad) begin
                                stat_next  = STAT_BAD_POS;
                                state_next = S_FINISH;
                            end else if (list_full) begin
                                stat_next  = STAT_FULL;
                                state_next = S_FINISH;
                            end else if (is_append) begin
                                state_next = S_PUT;
                            end else begin
                                // start with the last entry and walk toward the target
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(count_reg - CW'(1));
                                idx_next   = AW'(count_reg - CW'(1));
                                state_next = S_SHIFT;
                            end
                        end
                        MODE_DELETE: begin
                            if (count_reg == '0) begin
                                stat_next = STAT_EMPTY;
                            end else begin
                                count_next = count_reg - CW'(1);
                                stat_next  = STAT_DONE;
                            end
                            state_next = S_FINISH;
                        end
                        MODE_SEARCH: begin
                            if (count_reg == '0) begin
                                stat_next  = STAT_EMPTY;
                                state_next = S_FINISH;
                            end else begin
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                            stat_next  = STAT_BAD_POS;
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                // read data holds entry idx; it moves one slot back
                mem_we    = 1'b1;
                mem_waddr = idx_reg + AW'(1);
                mem_wdata = mem_rdata;
                if (idx_reg == tgt_reg) begin
                    state_next = S_PUT;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg - AW'(1);
                    idx_next  = idx_reg - AW'(1);
                end
            end
            S_PUT: begin
                mem_we     = 1'b1;
                mem_waddr  = tgt_reg;
                mem_wdata  = val_reg;
                count_next = count_reg + CW'(1);
                stat_next  = STAT_DONE;
                state_next = S_FINISH;
            end
            S_SCAN: begin
                if (mem_rdata == key_reg) begin
                    stat_next  = STAT_DONE;
                    fpos_next  = POS_W'(CW'(idx_reg) + CW'(1));
                    state_next = S_FINISH;
                end else if (CW'(idx_reg) == count_reg - CW'(1)) begin
                    stat_next  = STAT_NOT_FOUND;
                    state_next = S_FINISH;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg + AW'(1);
                    idx_next  = idx_reg + AW'(1);
                end
            end
            S_FINISH: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        tgt_reg  <= tgt_next;
        val_reg  <= val_next;
        key_reg  <= key_next;
        stat_reg <= stat_next;
        fpos_reg <= fpos_next;
    end

    assign in_ready           = (state_reg == S_IDLE);
    assign res_valid          = (state_reg == S_FINISH);
    assign res.status         = stat_reg;
    assign res.found_position = fpos_reg;
    assign res.entry_count    = POS_W'(count_reg);

endmodule

FILE: sv/positional_list_engine.sv
// positional_list_engine: bounded ordered list with insert, delete-rear and search
// top level; instantiates plm_ctrl and plm_store, depends on plm_pkg
//
//   channel   dir   tdata (low bit up)                          tuser
//   s_        in    position[6:0] item_value[38:7]              mode[1:0]
//                   search_key[70:39] zero[71]
//   m_        out   status[2:0] found_position[9:3]             -
//                   entry_count[16:10] zero[23:17]
//
// one item at a time; the memory's single read and single write port set the pace
// insert at p: entries last..p shift back one slot, then the item is written at p
// search scans from entry 1; delete, bad or full requests do not touch the store
// reset clears the entry count but not the store, no clearing pass; store contents are don't-care
// a finished result waits in the output register while the next item is accepted
module positional_list_engine
    import plm_pkg::*;
#(
    parameter int unsigned CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // position, item_value, search_key
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // status, found_position, entry_count
);

    localparam int unsigned AW = $clog2(CAPACITY);

    // controller to output stage
    plm_result_t       res;
    logic              res_valid;
    logic              res_ready;

    // memory port
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [VALUE_W-1:0] mem_rdata;

    // output register
    plm_result_t       out_reg;
    logic              out_valid_reg;

    plm_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_mode       (s_tuser),
        .in_position   (s_tdata[6:0]),
        .in_item_value (s_tdata[38:7]),
        .in_search_key (s_tdata[70:39]),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata)
    );

    plm_store #(
        .DEPTH (CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // output slot frees up when empty or being taken this cycle
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_reg.entry_count, out_reg.found_position, out_reg.status};

    // a position is only reported with a successful search
    a_fpos_done: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_reg.found_position != '0) |-> out_reg.status == STAT_DONE)
        else $error("found position reported without done status");

    // sequential operation: an accepted item always occupies the controller
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("new item accepted right after another");

    // the count never passes the capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (CAPACITY <= 127) |-> out_reg.entry_count <= POS_W'(CAPACITY))
        else $error("entry count above capacity");

    // a match lies within the list
    a_fpos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (CAPACITY <= 127) && (out_reg.found_position != '0)
        |-> out_reg.found_position <= out_reg.entry_count)
        else $error("found position beyond the list");

    // a result handed to a free slot shows on the port next cycle
    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_ready |=> m_tvalid)
        else $error("result lost on the way to the output");

endmodule
